// ----- design/nearest_point_table_lookup_top_macros.svh -----
// Assertion macros shared by the nearest point table lookup design.
`ifndef NEAREST_POINT_TABLE_LOOKUP_TOP_MACROS_SVH
`define NEAREST_POINT_TABLE_LOOKUP_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NPT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define NPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- design/npt_pkg.sv -----
// Package with the types, constants and codes of the nearest point table lookup.
`default_nettype none
package npt_pkg;

   localparam int MAX_POINTS = 64;
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int EXP_W      = 25;
   localparam int STR_W      = 33;
   localparam int VOL_W      = 25;
   localparam int DIST_W     = STR_W + 3;

   typedef logic [1:0]              opcode_type;
   typedef logic [1:0]              status_type;
   typedef logic signed [EXP_W-1:0] expiry_type;
   typedef logic signed [STR_W-1:0] strike_type;
   typedef logic signed [VOL_W-1:0] vol_type;
   typedef logic [DIST_W-1:0]       dist_type;
   typedef logic [CNT_W-1:0]        count_type;

   localparam opcode_type OP_CLEAR = 2'd0;
   localparam opcode_type OP_ADD   = 2'd1;
   localparam opcode_type OP_QUERY = 2'd2;

   localparam status_type STATUS_OK       = 2'd0;
   localparam status_type STATUS_INVALID  = 2'd1;
   localparam status_type STATUS_CAPACITY = 2'd2;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SCAN = 2'b10
   } state_type;

   // Query token that walks down the row of cells.
   typedef struct packed {
      logic       valid;
      logic       found;
      expiry_type expiry;
      strike_type strike;
      dist_type   best_dist;
      vol_type    best_vol;
   } token_type;

endpackage
`default_nettype wire

// ----- design/npt_cell.sv -----
// One table cell: holds a point and updates the passing query token.
`default_nettype none
module npt_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               load,
   input  wire npt_pkg::expiry_type load_expiry,
   input  wire npt_pkg::strike_type load_strike,
   input  wire npt_pkg::vol_type    load_vol,
   input  wire logic               active,
   input  wire npt_pkg::token_type  token_in,
   output npt_pkg::token_type       token_out
);
   import npt_pkg::*;

   expiry_type expiry_ff;
   strike_type strike_ff;
   vol_type    vol_ff;
   token_type  token_ff;
   token_type  token_in_next;

   logic signed [EXP_W:0] exp_diff;
   logic signed [STR_W:0] str_diff;
   logic [EXP_W:0]        exp_abs;
   logic [STR_W:0]        str_abs;
   dist_type              point_dist;
   logic                  take;

   always_comb begin
      exp_diff = {expiry_ff[EXP_W-1], expiry_ff} - {token_in.expiry[EXP_W-1], token_in.expiry};
      str_diff = {strike_ff[STR_W-1], strike_ff} - {token_in.strike[STR_W-1], token_in.strike};
      exp_abs  = exp_diff[EXP_W] ? (EXP_W+1)'(-exp_diff) : exp_diff;
      str_abs  = str_diff[STR_W] ? (STR_W+1)'(-str_diff) : str_diff;
      point_dist = DIST_W'(exp_abs) + DIST_W'(str_abs);
      take     = active && (!token_in.found || (point_dist < token_in.best_dist));
      token_in_next = token_in;
      if (take) begin
         token_in_next.found     = 1'b1;
         token_in_next.best_dist = point_dist;
         token_in_next.best_vol  = vol_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         expiry_ff <= load_expiry;
         strike_ff <= load_strike;
         vol_ff    <= load_vol;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff.valid <= 1'b0;
      end else begin
         token_ff.valid <= token_in_next.valid;
      end
      token_ff.found     <= token_in_next.found;
      token_ff.expiry    <= token_in_next.expiry;
      token_ff.strike    <= token_in_next.strike;
      token_ff.best_dist <= token_in_next.best_dist;
      token_ff.best_vol  <= token_in_next.best_vol;
   end

   assign token_out = token_ff;

endmodule
`default_nettype wire

// ----- design/nearest_point_table_lookup_top.sv -----
// Top level of the nearest point table lookup: command decode, point count, cell row.
// Clear and add are registered: the result strobes in the cycle after start, and
// busy stays low, so a new item may start in that same cycle.
// A query walks a token through MAX_POINTS cells, one cell per cycle, and its result
// is registered once more after the last cell; busy is high while the token is in the row.
// No new item is accepted while busy is high, so queries run one at a time.
// Reset empties the table and drops any query in flight; the receiver cannot stall.
`default_nettype none
`include "nearest_point_table_lookup_top_macros.svh"
module nearest_point_table_lookup_top (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire npt_pkg::opcode_type req_opcode,
   input  wire npt_pkg::expiry_type req_expiry,
   input  wire npt_pkg::strike_type req_strike,
   input  wire npt_pkg::vol_type    req_vol_in,
   output logic                     rsp_valid,
   output npt_pkg::status_type      rsp_status,
   output npt_pkg::vol_type         rsp_vol_out
);
   import npt_pkg::*;

   state_type  state_ff, state_in;
   count_type  count_ff, count_in;
   logic       rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff, rsp_status_in;
   vol_type    rsp_vol_ff, rsp_vol_in;

   logic      accept;
   logic      add_fields_ok;
   logic      add_ok;
   token_type chain [0:MAX_POINTS];

   assign busy   = (state_ff == S_SCAN);
   assign accept = start && !busy;

   assign add_fields_ok = !req_expiry[EXP_W-1] && !req_strike[STR_W-1] && !req_vol_in[VOL_W-1];
   assign add_ok = accept && (req_opcode == OP_ADD) && add_fields_ok
                   && (count_ff < CNT_W'(MAX_POINTS));

   always_comb begin
      chain[0].valid     = accept && (req_opcode == OP_QUERY);
      chain[0].found     = 1'b0;
      chain[0].expiry    = req_expiry;
      chain[0].strike    = req_strike;
      chain[0].best_dist = '0;
      chain[0].best_vol  = '0;
   end

   for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
      npt_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .load        (add_ok && (count_ff == CNT_W'(i))),
         .load_expiry (req_expiry),
         .load_strike (req_strike),
         .load_vol    (req_vol_in),
         .active      (CNT_W'(i) < count_ff),
         .token_in    (chain[i]),
         .token_out   (chain[i+1])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (accept && (req_opcode == OP_CLEAR)) begin
         count_in = '0;
      end else if (add_ok) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_opcode == OP_QUERY)) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (chain[MAX_POINTS].valid) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in  = 1'b0;
      rsp_status_in = STATUS_INVALID;
      rsp_vol_in    = '0;
      priority if (accept && (req_opcode != OP_QUERY)) begin
         rsp_valid_in = 1'b1;
         unique case (req_opcode)
            OP_CLEAR: rsp_status_in = STATUS_OK;
            OP_ADD: begin
               if (!add_fields_ok) begin
                  rsp_status_in = STATUS_INVALID;
               end else if (count_ff >= CNT_W'(MAX_POINTS)) begin
                  rsp_status_in = STATUS_CAPACITY;
               end else begin
                  rsp_status_in = STATUS_OK;
               end
            end
            default: rsp_status_in = STATUS_INVALID;
         endcase
      end else if (chain[MAX_POINTS].valid) begin
         rsp_valid_in = 1'b1;
         if (chain[MAX_POINTS].found) begin
            rsp_status_in = STATUS_OK;
            rsp_vol_in    = chain[MAX_POINTS].best_vol;
         end
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_vol_ff    <= rsp_vol_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_vol_out = rsp_vol_ff;

   `NPT_ASSERT_SAME(a_token_exits_in_scan, clock, reset, chain[MAX_POINTS].valid, state_ff == S_SCAN)
   `NPT_ASSERT_NEXT(a_cmd_rsp_next, clock, reset, accept && (req_opcode != OP_QUERY), rsp_valid)
   `NPT_ASSERT_SAME(a_count_bounded, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_POINTS))
   `NPT_ASSERT_SAME(a_no_rsp_in_scan, clock, reset, busy, !rsp_valid)

endmodule
`default_nettype wire

// ----- sim/tb_nearest_point_table_lookup_top.sv -----
// Self-checking testbench for the nearest point table lookup top level.
`timescale 1ns / 100ps
module tb_nearest_point_table_lookup_top;
   import npt_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = MAX_POINTS + 16;

   localparam int RANGE_FULL     = 0;
   localparam int RANGE_POSITIVE = 1;
   localparam int RANGE_GRID     = 2;
   localparam int RANGE_NEAR     = 3;

   typedef struct {
      status_type status;
      vol_type    vol;
   } lookup_reply_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   opcode_type req_opcode = OP_CLEAR;
   expiry_type req_expiry = '0;
   strike_type req_strike = '0;
   vol_type    req_vol_in = '0;
   logic       rsp_valid;
   status_type rsp_status;
   vol_type    rsp_vol_out;

   expiry_type       stored_expiry [MAX_POINTS];
   strike_type       stored_strike [MAX_POINTS];
   vol_type          stored_vol [MAX_POINTS];
   int               stored_points = 0;
   lookup_reply_type awaited_replies[$];
   int               mismatches = 0;
   int               items_sent = 0;
   int               sender_idle_pct = 0;
   int               quiet_cycles = 0;

   nearest_point_table_lookup_top u_top (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_opcode  (req_opcode),
      .req_expiry  (req_expiry),
      .req_strike  (req_strike),
      .req_vol_in  (req_vol_in),
      .rsp_valid   (rsp_valid),
      .rsp_status  (rsp_status),
      .rsp_vol_out (rsp_vol_out)
   );

   always #2 clock = ~clock;

   function automatic lookup_reply_type predict_reply(opcode_type op, expiry_type e,
                                                      strike_type s, vol_type v);
      lookup_reply_type r;
      longint           d_e;
      longint           d_s;
      longint           best_d;
      int               best;
      r.status = STATUS_INVALID;
      r.vol    = '0;
      best     = 0;
      best_d   = 0;
      case (op)
         OP_CLEAR: begin
            stored_points = 0;
            r.status = STATUS_OK;
         end
         OP_ADD: begin
            if (e[EXP_W-1] || s[STR_W-1] || v[VOL_W-1]) begin
               r.status = STATUS_INVALID;
            end else if (stored_points >= MAX_POINTS) begin
               r.status = STATUS_CAPACITY;
            end else begin
               stored_expiry[stored_points] = e;
               stored_strike[stored_points] = s;
               stored_vol[stored_points]    = v;
               stored_points++;
               r.status = STATUS_OK;
            end
         end
         OP_QUERY: begin
            if (stored_points != 0) begin
               for (int i = 0; i < stored_points; i++) begin
                  d_e = longint'(stored_expiry[i]) - longint'(e);
                  d_s = longint'(stored_strike[i]) - longint'(s);
                  if (d_e < 0) d_e = -d_e;
                  if (d_s < 0) d_s = -d_s;
                  if (i == 0 || d_e + d_s < best_d) begin
                     best_d = d_e + d_s;
                     best   = i;
                  end
               end
               r.status = STATUS_OK;
               r.vol    = stored_vol[best];
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic expiry_type pick_expiry(int range_code);
      case (range_code)
         RANGE_FULL:     return expiry_type'($urandom);
         RANGE_POSITIVE: return expiry_type'($urandom_range(0, 24'hFFFFFF));
         RANGE_GRID:     return expiry_type'($urandom_range(0, 8));
         default:        return expiry_type'(int'($urandom_range(0, 12)) - 2);
      endcase
   endfunction

   function automatic strike_type pick_strike(int range_code);
      case (range_code)
         RANGE_FULL:     return strike_type'({$urandom, $urandom});
         RANGE_POSITIVE: return strike_type'({1'b0, $urandom});
         RANGE_GRID:     return strike_type'($urandom_range(0, 8));
         default:        return strike_type'(int'($urandom_range(0, 12)) - 2);
      endcase
   endfunction

   function automatic vol_type pick_vol(int range_code);
      if (range_code == RANGE_FULL) begin
         return vol_type'($urandom);
      end
      return vol_type'($urandom_range(0, 24'hFFFFFF));
   endfunction

   task automatic report_mismatch(string what, longint wanted, longint seen);
      mismatches++;
      if (mismatches <= 10) begin
         $display("MISMATCH at %0t: %s expected %0d actual %0d", $realtime, what, wanted, seen);
      end
   endtask

   task automatic send_item(opcode_type op, expiry_type e, strike_type s, vol_type v);
      start      <= 1'b1;
      req_opcode <= op;
      req_expiry <= e;
      req_strike <= s;
      req_vol_in <= v;
      @(posedge clock);
      while (busy) @(posedge clock);
      awaited_replies.push_back(predict_reply(op, e, s, v));
      items_sent++;
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < sender_idle_pct);
      end
   endtask

   task automatic wait_drain();
      start <= 1'b0;
      @(posedge clock);
      while (awaited_replies.size() != 0) @(posedge clock);
   endtask

   task automatic test_empty_table();
      send_item(OP_QUERY, expiry_type'(-(1 << 24)), strike_type'(-(64'sd1 <<< 32)), '0);
      send_item(opcode_type'(3), '1, '1, '1);
      send_item(OP_CLEAR, '0, '0, '0);
      send_item(OP_QUERY, '0, '0, '0);
      wait_drain();
   endtask

   task automatic test_add_screening();
      send_item(OP_ADD, expiry_type'(-1), strike_type'(5), vol_type'(7));
      send_item(OP_ADD, expiry_type'(5), strike_type'(-1), vol_type'(7));
      send_item(OP_ADD, expiry_type'(5), strike_type'(5), vol_type'(-1));
      send_item(OP_ADD, expiry_type'(-(1 << 24)), strike_type'(-(64'sd1 <<< 32)),
                vol_type'(-(1 << 24)));
      send_item(OP_ADD, expiry_type'(24'hFFFFFF), strike_type'(32'hFFFFFFFF),
                vol_type'(24'hFFFFFF));
      send_item(OP_ADD, '0, '0, vol_type'(24'h123456));
      send_item(opcode_type'(3), '0, '0, vol_type'(99));
      send_item(OP_QUERY, expiry_type'(24'hFFFFFF), strike_type'(32'hFFFFFFFF), '0);
      send_item(OP_QUERY, expiry_type'(-(1 << 24)), strike_type'(-(64'sd1 <<< 32)), '1);
      wait_drain();
   endtask

   task automatic test_distance_ties();
      send_item(OP_CLEAR, '0, '0, '0);
      send_item(OP_ADD, expiry_type'(10), strike_type'(0), vol_type'(111));
      send_item(OP_ADD, expiry_type'(0), strike_type'(10), vol_type'(222));
      send_item(OP_QUERY, expiry_type'(5), strike_type'(5), '0);
      send_item(OP_ADD, expiry_type'(5), strike_type'(5), vol_type'(333));
      send_item(OP_QUERY, expiry_type'(3), strike_type'(3), '0);
      wait_drain();
   endtask

   task automatic test_full_table();
      int slot;
      send_item(OP_CLEAR, '0, '0, '0);
      repeat (MAX_POINTS) begin
         send_item(OP_ADD, pick_expiry(RANGE_POSITIVE), pick_strike(RANGE_POSITIVE),
                   pick_vol(RANGE_POSITIVE));
      end
      send_item(OP_ADD, pick_expiry(RANGE_POSITIVE), pick_strike(RANGE_POSITIVE),
                pick_vol(RANGE_POSITIVE));
      send_item(OP_ADD, pick_expiry(RANGE_POSITIVE), strike_type'(-1),
                pick_vol(RANGE_POSITIVE));
      repeat (3) begin
         send_item(OP_QUERY, pick_expiry(RANGE_FULL), pick_strike(RANGE_FULL),
                   pick_vol(RANGE_FULL));
         slot = $urandom_range(0, MAX_POINTS - 1);
         send_item(OP_QUERY, stored_expiry[slot], stored_strike[slot], pick_vol(RANGE_FULL));
      end
      send_item(OP_CLEAR, '0, '0, '0);
      send_item(OP_QUERY, pick_expiry(RANGE_FULL), pick_strike(RANGE_FULL), '0);
      wait_drain();
   endtask

   task automatic test_random_traffic(int item_goal);
      int first_item;
      int pick;
      int point_range;
      int query_range;
      first_item = items_sent;
      while (items_sent - first_item < item_goal) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            point_range = $urandom_range(0, 1) ? RANGE_GRID : RANGE_POSITIVE;
            query_range = (point_range == RANGE_GRID) ? RANGE_NEAR : RANGE_FULL;
            if ($urandom_range(0, 1)) begin
               send_item(OP_CLEAR, pick_expiry(RANGE_FULL), pick_strike(RANGE_FULL),
                         pick_vol(RANGE_FULL));
            end
            repeat ($urandom_range(1, 8)) begin
               send_item(OP_ADD, pick_expiry(point_range), pick_strike(point_range),
                         pick_vol(RANGE_POSITIVE));
            end
            repeat ($urandom_range(1, 4)) begin
               send_item(OP_QUERY, pick_expiry(query_range), pick_strike(query_range),
                         pick_vol(RANGE_FULL));
            end
         end else begin
            send_item(opcode_type'($urandom_range(0, 3)), pick_expiry(RANGE_FULL),
                      pick_strike(RANGE_FULL), pick_vol(RANGE_FULL));
            if (pick == 9) begin
               wait_drain();
            end
         end
      end
      wait_drain();
   endtask

   always @(posedge clock) begin
      lookup_reply_type wanted;
      if (!reset) begin
         if (rsp_valid) begin
            if (awaited_replies.size() == 0) begin
               report_mismatch("unrequested result, status", -1, rsp_status);
            end else begin
               wanted = awaited_replies.pop_front();
               if (rsp_status !== wanted.status) begin
                  report_mismatch("status", wanted.status, rsp_status);
               end
               if (rsp_vol_out !== wanted.vol) begin
                  report_mismatch("vol_out", wanted.vol, rsp_vol_out);
               end
            end
         end
         if ((start && !busy) || rsp_valid) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired at %0t", $realtime);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      sender_idle_pct = 16;
      test_empty_table();
      test_add_screening();
      test_distance_ties();
      test_full_table();
      test_random_traffic(400);
      sender_idle_pct = 70;
      test_full_table();
      test_random_traffic(400);
      sender_idle_pct = 0;
      test_full_table();
      test_random_traffic(400);
      wait_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (awaited_replies.size() != 0) begin
         report_mismatch("results still outstanding", 0, awaited_replies.size());
      end
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
